// ===== sv/lcdw_pkg.sv =====
// ----------------------------------------------------------------------------
// lcdw_pkg
// Shared types, codes and constants for the character LCD write sequencer.
// ----------------------------------------------------------------------------
package lcdw_pkg;

  localparam int unsigned CMD_W      = 2;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned NIB_W      = 4;
  localparam int unsigned HOLD_W     = 18;
  localparam int unsigned PULSE_W    = 10;
  localparam int unsigned SETTLE_W   = 14;
  localparam int unsigned GAP_W      = 14;
  localparam int unsigned LONG_W     = 17;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned JOB_IDX_W  = 4;

  // Input item kinds
  localparam logic [CMD_W-1:0] CMD_COMMAND = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DATA    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SLOW    = 2'd2;
  localparam logic [CMD_W-1:0] CMD_INIT    = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PULSE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHAR_GAP  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_WAIT = 2'd3;

  localparam logic [PULSE_W-1:0]  PULSE_RST     = 10'd1;
  localparam logic [SETTLE_W-1:0] SETTLE_RST    = 14'd100;
  localparam logic [GAP_W-1:0]    CHAR_GAP_RST  = 14'd80;
  localparam logic [LONG_W-1:0]   LONG_WAIT_RST = 17'd4000;

  localparam logic [HOLD_W-1:0] POWERUP_WAIT_US = 18'd100000;
  localparam logic [LONG_W-1:0] RESET_WAIT1_US  = 17'd10000;
  localparam logic [LONG_W-1:0] RESET_WAIT2_US  = 17'd200;
  localparam logic [LONG_W-1:0] MODE_WAIT_US    = 17'd80;

  localparam logic [BYTE_W-1:0] BYTE_RESET    = 8'h30;
  localparam logic [BYTE_W-1:0] BYTE_FUNCSET  = 8'h28;
  localparam logic [BYTE_W-1:0] BYTE_CLEAR    = 8'h01;
  localparam logic [BYTE_W-1:0] BYTE_DISP_OFF = 8'h08;
  localparam logic [BYTE_W-1:0] BYTE_DISP_ON  = 8'h0C;

  localparam logic [JOB_IDX_W-1:0] BYTE_LAST_IDX = 4'd1;
  localparam logic [JOB_IDX_W-1:0] INIT_LAST_IDX = 4'd12;

  localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

  // Extra wait added to the settle phase of a nibble
  typedef enum logic [2:0] {
    EX_NONE,
    EX_CHAR_GAP,
    EX_LONG_WAIT,
    EX_RESET1,
    EX_RESET2,
    EX_MODE
  } extra_e;

  // One nibble transfer (or the power-up wait) handed from front to back
  typedef struct packed {
    logic             powerup;
    logic             rs;
    logic [NIB_W-1:0] nibble;
    extra_e           extra;
    logic             last;
  } job_t;

  typedef struct packed {
    logic [PULSE_W-1:0]  pulse_us;
    logic [SETTLE_W-1:0] settle_us;
    logic [GAP_W-1:0]    char_gap_us;
    logic [LONG_W-1:0]   long_wait_us;
  } cfg_t;

  function automatic job_t mk_job(logic rs, logic [NIB_W-1:0] nib, extra_e ex, logic last);
    job_t j;
    j.powerup = 1'b0;
    j.rs      = rs;
    j.nibble  = nib;
    j.extra   = ex;
    j.last    = last;
    return j;
  endfunction

  // Power-up init sequence: the power-up wait, then one entry per nibble
  function automatic job_t init_job(logic [JOB_IDX_W-1:0] idx);
    job_t j;
    j = mk_job(1'b0, '0, EX_NONE, 1'b0);
    case (idx)
      4'd0: j.powerup = 1'b1;
      4'd1:  j = mk_job(1'b0, BYTE_RESET[7:4],    EX_RESET1,    1'b0);
      4'd2:  j = mk_job(1'b0, BYTE_RESET[7:4],    EX_RESET2,    1'b0);
      4'd3:  j = mk_job(1'b0, BYTE_RESET[7:4],    EX_RESET2,    1'b0);
      4'd4:  j = mk_job(1'b0, BYTE_FUNCSET[7:4],  EX_MODE,      1'b0);
      4'd5:  j = mk_job(1'b0, BYTE_FUNCSET[7:4],  EX_NONE,      1'b0);
      4'd6:  j = mk_job(1'b0, BYTE_FUNCSET[3:0],  EX_MODE,      1'b0);
      4'd7:  j = mk_job(1'b0, BYTE_DISP_OFF[7:4], EX_NONE,      1'b0);
      4'd8:  j = mk_job(1'b0, BYTE_DISP_OFF[3:0], EX_LONG_WAIT, 1'b0);
      4'd9:  j = mk_job(1'b0, BYTE_CLEAR[7:4],    EX_NONE,      1'b0);
      4'd10: j = mk_job(1'b0, BYTE_CLEAR[3:0],    EX_LONG_WAIT, 1'b0);
      4'd11: j = mk_job(1'b0, BYTE_DISP_ON[7:4],  EX_NONE,      1'b0);
      4'd12: j = mk_job(1'b0, BYTE_DISP_ON[3:0],  EX_LONG_WAIT, 1'b1);
      default: j = mk_job(1'b0, '0, EX_NONE, 1'b1);
    endcase
    return j;
  endfunction

endpackage

// ===== sv/lcdw_front.sv =====
// ----------------------------------------------------------------------------
// lcdw_front
// Accepts input items and splits each into nibble jobs (an init item into the power-up sequence) for the queue.
// ----------------------------------------------------------------------------
module lcdw_front import lcdw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  logic [CMD_W-1:0]  cmd_i,
  input  logic [BYTE_W-1:0] byte_i,
  output logic              push_o,
  output job_t              job_o,
  input  logic              full_i
);

  logic                 busy_q, busy_d;
  logic [JOB_IDX_W-1:0] idx_q, idx_d;
  logic [CMD_W-1:0]     cmd_q;
  logic [BYTE_W-1:0]    byte_q;
  logic [JOB_IDX_W-1:0] last_idx;
  logic                 accept;
  extra_e               byte_extra;

  assign ready_o  = !busy_q;
  assign accept   = valid_i && !busy_q;
  assign push_o   = busy_q && !full_i;
  assign last_idx = (cmd_q == CMD_INIT) ? INIT_LAST_IDX : BYTE_LAST_IDX;

  always_comb begin
    case (cmd_q)
      CMD_DATA: byte_extra = EX_CHAR_GAP;
      CMD_SLOW: byte_extra = EX_LONG_WAIT;
      default:  byte_extra = EX_NONE;
    endcase
  end

  always_comb begin
    if (cmd_q == CMD_INIT) begin
      job_o = init_job(idx_q);
    end else if (idx_q == '0) begin
      job_o = mk_job(cmd_q == CMD_DATA, byte_q[7:4], EX_NONE, 1'b0);
    end else begin
      job_o = mk_job(cmd_q == CMD_DATA, byte_q[3:0], byte_extra, 1'b1);
    end
  end

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (accept) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end else if (push_o) begin
      if (idx_q == last_idx) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= cmd_i;
      byte_q <= byte_i;
    end
  end

endmodule

// ===== sv/lcdw_queue.sv =====
// ----------------------------------------------------------------------------
// lcdw_queue
// Small FIFO of nibble jobs between the front and back ends.
// ----------------------------------------------------------------------------
module lcdw_queue import lcdw_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output job_t pop_data_o,
  output logic empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  job_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o     = (count_q == CNT_W'(DEPTH));
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== sv/lcdw_back.sv =====
// ----------------------------------------------------------------------------
// lcdw_back
// Turns each nibble job into low/high/low enable events with hold times; a power-up job gives one enable-low wait.
// ----------------------------------------------------------------------------
module lcdw_back import lcdw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  job_t              job_i,
  input  logic              empty_i,
  output logic              pop_o,
  output logic              valid_o,
  input  logic              ready_i,
  output logic              rs_o,
  output logic              enable_o,
  output logic [NIB_W-1:0]  nibble_o,
  output logic [HOLD_W-1:0] hold_o,
  output logic              last_o
);

  localparam logic [1:0] PH_LOW    = 2'd0;
  localparam logic [1:0] PH_HIGH   = 2'd1;
  localparam logic [1:0] PH_SETTLE = 2'd2;

  job_t              job_q;
  logic              job_valid_q, job_valid_d;
  logic [1:0]        phase_q, phase_d;
  logic              out_valid_q, out_valid_d;
  logic              can_load, fire, final_ph;
  logic [LONG_W-1:0] extra;
  logic [HOLD_W-1:0] hold_d;

  assign can_load = !out_valid_q || ready_i;
  assign fire     = job_valid_q && can_load;
  assign final_ph = job_q.powerup || (phase_q == PH_SETTLE);
  assign pop_o    = !job_valid_q && !empty_i;
  assign valid_o  = out_valid_q;

  always_comb begin
    case (job_q.extra)
      EX_CHAR_GAP:  extra = LONG_W'(cfg_i.char_gap_us);
      EX_LONG_WAIT: extra = cfg_i.long_wait_us;
      EX_RESET1:    extra = RESET_WAIT1_US;
      EX_RESET2:    extra = RESET_WAIT2_US;
      EX_MODE:      extra = MODE_WAIT_US;
      default:      extra = '0;
    endcase
  end

  always_comb begin
    if (job_q.powerup) begin
      hold_d = POWERUP_WAIT_US;
    end else if (phase_q == PH_SETTLE) begin
      hold_d = HOLD_W'(cfg_i.settle_us) + HOLD_W'(extra);
    end else begin
      hold_d = HOLD_W'(cfg_i.pulse_us);
    end
  end

  always_comb begin
    job_valid_d = job_valid_q;
    phase_d     = phase_q;
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (ready_i) begin
      out_valid_d = 1'b0;
    end
    if (pop_o) begin
      job_valid_d = 1'b1;
      phase_d     = PH_LOW;
    end else if (fire) begin
      if (final_ph) begin
        job_valid_d = 1'b0;
      end else begin
        phase_d = phase_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      phase_q     <= PH_LOW;
      out_valid_q <= 1'b0;
    end else begin
      job_valid_q <= job_valid_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end
    if (fire) begin
      rs_o     <= job_q.rs;
      enable_o <= (phase_q == PH_HIGH) && !job_q.powerup;
      nibble_o <= job_q.powerup ? '0 : job_q.nibble;
      hold_o   <= hold_d;
      last_o   <= job_q.last && final_ph;
    end
  end

endmodule

// ===== sv/char_lcd_4bit_write_sequencer_core.sv =====
// An accepted item passes the front end, the queue and the back end's job register before its
// first event is registered; then one event per cycle while the output is taken, with a fetch
// from the queue between nibbles. A byte item gives two nibbles of low/high/settle events.
// Input is taken again once the front end has queued every nibble of an item.
// Reset (rst_ni low, async) empties the queue and loads register defaults.
// ----------------------------------------------------------------------------
// char_lcd_4bit_write_sequencer_core
// HD44780-style 4-bit bus write sequencer producing timed pin events.
// ----------------------------------------------------------------------------
module char_lcd_4bit_write_sequencer_core import lcdw_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [7:0] byte_value
  input  logic [1:0]            s_axis_tuser,   // [1:0] cmd
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [23:0]           m_axis_tdata,   // [0] enable, [4:1] nibble, [22:5] hold_us
  output logic                  m_axis_tuser,   // [0] rs
  output logic                  m_axis_tlast
);

  cfg_t              cfg_q;
  logic              push, full, pop, empty;
  job_t              push_job, pop_job;
  logic              ev_enable;
  logic [NIB_W-1:0]  ev_nibble;
  logic [HOLD_W-1:0] ev_hold;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pulse_us     <= PULSE_RST;
      cfg_q.settle_us    <= SETTLE_RST;
      cfg_q.char_gap_us  <= CHAR_GAP_RST;
      cfg_q.long_wait_us <= LONG_WAIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PULSE:     cfg_q.pulse_us     <= cfg_data_i[PULSE_W-1:0];
        REG_SETTLE:    cfg_q.settle_us    <= cfg_data_i[SETTLE_W-1:0];
        REG_CHAR_GAP:  cfg_q.char_gap_us  <= cfg_data_i[GAP_W-1:0];
        REG_LONG_WAIT: cfg_q.long_wait_us <= cfg_data_i[LONG_W-1:0];
        default: ;
      endcase
    end
  end

  lcdw_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .cmd_i   (s_axis_tuser),
    .byte_i  (s_axis_tdata),
    .push_o  (push),
    .job_o   (push_job),
    .full_i  (full)
  );

  lcdw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_job),
    .empty_o     (empty)
  );

  lcdw_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .job_i    (pop_job),
    .empty_i  (empty),
    .pop_o    (pop),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .rs_o     (m_axis_tuser),
    .enable_o (ev_enable),
    .nibble_o (ev_nibble),
    .hold_o   (ev_hold),
    .last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, ev_hold, ev_nibble, ev_enable};

  // Front end takes one item at a time
  a_ready_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while front end busy");

  // Enable-high phase is never the final event of an item
  a_high_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[0]) |-> !m_axis_tlast)
    else $error("last flag on enable-high event");

  // Enable-high phase holds for exactly the pulse time
  a_high_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tdata[22:5] == HOLD_W'(cfg_q.pulse_us)))
    else $error("enable-high hold differs from pulse time");

endmodule
